/* rtl/tlca_pkg.sv */
// Shared types, constants and state codes for the tree LCA block.
package tlca_pkg;

    localparam int NODE_W = 10;
    localparam int DIST_W = 11;
    localparam int VC_W   = 11;
    localparam logic [VC_W-1:0] VC_RESET = 11'd1024;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_LIFT_LEVELS  = 10;
    localparam int DEF_MAX_EDGES    = 2048;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NOT_BUILT = 3'd1,
        STS_RANGE     = 3'd2,
        STS_FULL      = 3'd3,
        STS_UNREACHED = 3'd4
    } status_t;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_DISPATCH,
        S_A_RDU, S_A_WRU, S_A_RDV, S_A_WRV,
        S_B_CLR, S_B_SEED, S_B_POP, S_B_POPW, S_B_HEADW, S_B_EDGE, S_B_TGTW, S_B_VIS,
        S_L_RD, S_L_RDW, S_L_WR,
        S_Q_VU, S_Q_VV, S_Q_VA, S_Q_VCHK,
        S_S_LD, S_S_DX, S_S_DY, S_S_SWAP, S_S_UP, S_S_UPW, S_S_EQ,
        S_S_DN, S_S_DNA, S_S_DNB, S_S_FIN, S_S_FINW, S_S_DL, S_S_DIST,
        S_RESP
    } state_t;

    typedef struct packed {
        cmd_t              op;
        logic              bad;
        logic [NODE_W-1:0] u;
        logic [NODE_W-1:0] v;
        logic [NODE_W-1:0] a;
    } tlca_item_t;

    typedef struct packed {
        logic       valid;
        tlca_item_t item;
    } tlca_req_t;

    typedef struct packed {
        logic ready;
        logic pop;
    } tlca_bk_t;

endpackage

/* rtl/tlca_front.sv */
// Front end: vertex count register, command range checks and a two-entry command queue.
module tlca_front import tlca_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    localparam int VN_W = $clog2(MAX_VERTICES) + 1,
    localparam int CW = (VN_W > VC_W) ? VN_W : VC_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [NODE_W-1:0] node_u,
    input  logic [NODE_W-1:0] node_v,
    input  logic [NODE_W-1:0] node_a,
    input  logic              cfg_we,
    input  logic [VC_W-1:0]   cfg_wdata,
    output logic [CW-1:0]     n_live,
    output tlca_req_t         req,
    input  tlca_bk_t          bk
);

    logic [VC_W-1:0] vc_reg;
    tlca_item_t      slot_reg [2];
    logic [1:0]      count_reg, count_next;
    logic            rd_ptr_reg, wr_ptr_reg;
    logic            push;
    logic            u_hi, v_hi, a_hi;
    cmd_t            cmd;
    tlca_item_t      item_in;

    always_comb
    begin
        if (vc_reg == '0)
            n_live = CW'(1);
        else if (CW'(vc_reg) > CW'(MAX_VERTICES))
            n_live = CW'(MAX_VERTICES);
        else
            n_live = CW'(vc_reg);
    end

    assign cmd  = cmd_t'(command);
    assign u_hi = CW'(node_u) >= n_live;
    assign v_hi = CW'(node_v) >= n_live;
    assign a_hi = CW'(node_a) >= n_live;

    always_comb
    begin
        item_in.op = cmd;
        item_in.u  = node_u;
        item_in.v  = node_v;
        item_in.a  = node_a;
        unique case (cmd)
            CMD_ADD:   item_in.bad = u_hi | v_hi;
            CMD_BUILD: item_in.bad = u_hi;
            CMD_QUERY: item_in.bad = u_hi | v_hi | a_hi;
            default:   item_in.bad = 1'b0;
        endcase
    end

    assign busy       = (count_reg == 2'd2) || !bk.ready;
    assign push       = start && !busy && (cmd != CMD_NONE);
    assign count_next = count_reg + {1'b0, push} - {1'b0, bk.pop};
    assign req.valid  = count_reg != 2'd0;
    assign req.item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg     <= VC_RESET;
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                vc_reg <= cfg_wdata;
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (bk.pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= item_in;
    end

endmodule

/* rtl/tlca_back.sv */
// Back end: edge store, breadth-first build, lifting table fill and LCA query sequencer.
module tlca_back import tlca_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int LIFT_LEVELS = DEF_LIFT_LEVELS,
    parameter int MAX_DIRECTED_EDGES = DEF_MAX_EDGES,
    localparam int VN_W = $clog2(MAX_VERTICES) + 1,
    localparam int CW = (VN_W > VC_W) ? VN_W : VC_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tlca_req_t         req,
    output tlca_bk_t          bk,
    input  logic              cfg_we,
    input  logic [CW-1:0]     n_live,
    output logic              done,
    output logic [2:0]        status,
    output logic [NODE_W-1:0] ancestor,
    output logic [DIST_W-1:0] distance,
    output logic              on_path
);

    localparam int V_W  = VN_W - 1;
    localparam int E_W  = $clog2(MAX_DIRECTED_EDGES);
    localparam int EN_W = E_W + 1;
    localparam int LW   = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int KW   = $clog2(LIFT_LEVELS + 1);
    localparam int AW   = LW + V_W;
    localparam int ANC_DEPTH = LIFT_LEVELS * (1 << V_W);
    localparam int SW   = V_W + 2;
    localparam int MW   = (SW > DIST_W) ? SW : DIST_W;
    localparam int DP_W = DIST_W + 1;
    localparam logic [VN_W-1:0] NONE    = VN_W'(MAX_VERTICES);
    localparam logic [EN_W-1:0] NO_EDGE = EN_W'(MAX_DIRECTED_EDGES);
    localparam logic [KW-1:0]   K_END   = KW'(LIFT_LEVELS);
    localparam logic [KW-1:0]   K_LAST  = KW'(LIFT_LEVELS - 1);

    // memories
    logic [EN_W-1:0] head_mem  [MAX_VERTICES];
    logic [V_W-1:0]  tgt_mem   [MAX_DIRECTED_EDGES];
    logic [EN_W-1:0] link_mem  [MAX_DIRECTED_EDGES];
    logic            vis_mem   [MAX_VERTICES];
    logic [V_W-1:0]  dep_mem   [MAX_VERTICES];
    logic [V_W-1:0]  que_mem   [MAX_VERTICES];
    logic [VN_W-1:0] anc_mem   [ANC_DEPTH];

    logic            h_we;
    logic [V_W-1:0]  h_waddr, h_raddr;
    logic [EN_W-1:0] h_wdata, h_rd;
    logic            e_we;
    logic [E_W-1:0]  e_waddr, e_raddr;
    logic [V_W-1:0]  tgt_wdata, tgt_rd;
    logic [EN_W-1:0] link_wdata, link_rd;
    logic            vi_we, vi_wdata, vi_rd;
    logic [V_W-1:0]  vi_waddr, vi_raddr;
    logic            dp_we;
    logic [V_W-1:0]  dp_waddr, dp_raddr, dp_wdata, dp_rd;
    logic            q_we;
    logic [V_W-1:0]  q_waddr, q_raddr, q_wdata, q_rd;
    logic            an_we;
    logic [AW-1:0]   an_waddr, an_raddr;
    logic [VN_W-1:0] an_wdata, an_rd;

    // sequencer state
    state_t          state_reg, state_next;
    logic [VN_W-1:0] cnt_reg;
    logic [EN_W-1:0] fill_reg;
    logic            built_reg;
    logic            done_reg;

    cmd_t            op_reg;
    logic            bad_reg;
    logic [V_W-1:0]  u_reg, v_reg, a_reg;
    status_t         status_reg;
    logic [VN_W-1:0] qh_reg, qt_reg;
    logic [V_W-1:0]  now_reg, cd_reg, nx_reg;
    logic [EN_W-1:0] e_reg;
    logic [KW-1:0]   k_reg;
    logic [V_W-1:0]  x_reg, y_reg, dx_reg, dy_reg, diff_reg, l_reg, anc_reg;
    logic [V_W:0]    sum_reg;
    logic [VN_W-1:0] p_reg;
    logic [1:0]      pair_reg;
    logic            ok_reg, onp_reg;
    logic [DIST_W-1:0] dist0_reg, dist1_reg;

    // conditions
    logic            fill_full, cnt_end, lift_done, e_end, nx_new, q_more;
    logic            p_ok, rd_ok, dbit;
    logic [V_W-1:0]  diff_sh, sel_x, sel_y;
    logic [KW-1:0]   kp1;
    logic [EN_W-1:0] fill_p1;
    logic [MW-1:0]   d_full;
    logic [DIST_W-1:0] d_cur;

    assign fill_full = ({1'b0, fill_reg} + (EN_W+1)'(2)) > (EN_W+1)'(MAX_DIRECTED_EDGES);
    assign fill_p1   = fill_reg + EN_W'(1);
    assign cnt_end   = CW'(cnt_reg) == n_live;
    assign kp1       = k_reg + KW'(1);
    assign lift_done = (int'(k_reg) + 1) >= LIFT_LEVELS;
    assign e_end     = e_reg >= NO_EDGE;
    assign nx_new    = (CW'(nx_reg) < n_live) && !vi_rd;
    assign q_more    = qh_reg < qt_reg;
    assign p_ok      = p_reg < NONE;
    assign rd_ok     = an_rd < NONE;
    assign diff_sh   = diff_reg >> k_reg;
    assign dbit      = diff_sh[0];
    assign d_full    = MW'(sum_reg) - (MW'(dp_rd) << 1);
    assign d_cur     = d_full[DIST_W-1:0];

    always_comb
    begin
        unique case (pair_reg)
            2'd0:    begin sel_x = u_reg; sel_y = v_reg; end
            2'd1:    begin sel_x = u_reg; sel_y = a_reg; end
            default: begin sel_x = a_reg; sel_y = v_reg; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            head_mem[h_waddr] <= h_wdata;
        h_rd <= head_mem[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            tgt_mem[e_waddr]  <= tgt_wdata;
            link_mem[e_waddr] <= link_wdata;
        end
        tgt_rd  <= tgt_mem[e_raddr];
        link_rd <= link_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vi_we)
            vis_mem[vi_waddr] <= vi_wdata;
        vi_rd <= vis_mem[vi_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dp_we)
            dep_mem[dp_waddr] <= dp_wdata;
        dp_rd <= dep_mem[dp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            que_mem[q_waddr] <= q_wdata;
        q_rd <= que_mem[q_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (an_we)
            anc_mem[an_waddr] <= an_wdata;
        an_rd <= anc_mem[an_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:     if (cnt_reg == VN_W'(MAX_VERTICES - 1)) state_next = S_IDLE;
            S_IDLE:     if (req.valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                unique case (op_reg)
                    CMD_ADD:   state_next = (bad_reg || fill_full) ? S_RESP : S_A_RDU;
                    CMD_BUILD: state_next = bad_reg ? S_RESP : S_B_CLR;
                    CMD_QUERY: state_next = (!built_reg || bad_reg) ? S_RESP : S_Q_VU;
                    default:   state_next = S_RESP;
                endcase
            end
            S_A_RDU:    state_next = S_A_WRU;
            S_A_WRU:    state_next = S_A_RDV;
            S_A_RDV:    state_next = S_A_WRV;
            S_A_WRV:    state_next = S_RESP;
            S_B_CLR:    if (cnt_end) state_next = S_B_SEED;
            S_B_SEED:   state_next = S_B_POP;
            S_B_POP:    state_next = q_more ? S_B_POPW : S_L_RD;
            S_B_POPW:   state_next = S_B_HEADW;
            S_B_HEADW:  state_next = S_B_EDGE;
            S_B_EDGE:   state_next = e_end ? S_B_POP : S_B_TGTW;
            S_B_TGTW:   state_next = S_B_VIS;
            S_B_VIS:    state_next = S_B_EDGE;
            S_L_RD:
            begin
                if (lift_done)
                    state_next = S_RESP;
                else if (!cnt_end)
                    state_next = S_L_RDW;
            end
            S_L_RDW:    state_next = S_L_WR;
            S_L_WR:     state_next = S_L_RD;
            S_Q_VU:     state_next = S_Q_VV;
            S_Q_VV:     state_next = S_Q_VA;
            S_Q_VA:     state_next = S_Q_VCHK;
            S_Q_VCHK:   state_next = (ok_reg && vi_rd) ? S_S_LD : S_RESP;
            S_S_LD:     state_next = S_S_DX;
            S_S_DX:     state_next = S_S_DY;
            S_S_DY:     state_next = S_S_SWAP;
            S_S_SWAP:   state_next = S_S_UP;
            S_S_UP:
            begin
                if (k_reg == K_END)
                    state_next = S_S_EQ;
                else if (dbit)
                    state_next = S_S_UPW;
            end
            S_S_UPW:    state_next = S_S_UP;
            S_S_EQ:     state_next = (x_reg == y_reg) ? S_S_DL : S_S_DN;
            S_S_DN:     state_next = S_S_DNA;
            S_S_DNA:    state_next = S_S_DNB;
            S_S_DNB:    state_next = (k_reg == '0) ? S_S_FIN : S_S_DN;
            S_S_FIN:    state_next = S_S_FINW;
            S_S_FINW:   state_next = S_S_DL;
            S_S_DL:     state_next = S_S_DIST;
            S_S_DIST:   state_next = (pair_reg == 2'd2) ? S_RESP : S_S_LD;
            S_RESP:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // memory controls
    always_comb
    begin
        bk.ready   = state_reg != S_INIT;
        bk.pop     = 1'b0;
        h_we       = 1'b0;
        h_waddr    = u_reg;
        h_wdata    = fill_reg;
        h_raddr    = u_reg;
        e_we       = 1'b0;
        e_waddr    = fill_reg[E_W-1:0];
        e_raddr    = e_reg[E_W-1:0];
        tgt_wdata  = v_reg;
        link_wdata = h_rd;
        vi_we      = 1'b0;
        vi_waddr   = nx_reg;
        vi_wdata   = 1'b1;
        vi_raddr   = tgt_rd;
        dp_we      = 1'b0;
        dp_waddr   = nx_reg;
        dp_wdata   = cd_reg + V_W'(1);
        dp_raddr   = l_reg;
        q_we       = 1'b0;
        q_waddr    = qt_reg[V_W-1:0];
        q_wdata    = nx_reg;
        q_raddr    = qh_reg[V_W-1:0];
        an_we      = 1'b0;
        an_waddr   = {LW'(0), nx_reg};
        an_wdata   = VN_W'(now_reg);
        an_raddr   = {k_reg[LW-1:0], x_reg};
        unique case (state_reg)
            S_INIT:
            begin
                h_we    = 1'b1;
                h_waddr = cnt_reg[V_W-1:0];
                h_wdata = NO_EDGE;
            end
            S_IDLE:   bk.pop = req.valid;
            S_A_RDU:  h_raddr = u_reg;
            S_A_WRU:
            begin
                e_we = 1'b1;
                h_we = 1'b1;
            end
            S_A_RDV:  h_raddr = v_reg;
            S_A_WRV:
            begin
                e_we      = 1'b1;
                e_waddr   = fill_p1[E_W-1:0];
                tgt_wdata = u_reg;
                h_we      = 1'b1;
                h_waddr   = v_reg;
                h_wdata   = fill_p1;
            end
            S_B_CLR:
            begin
                if (!cnt_end)
                begin
                    vi_we    = 1'b1;
                    vi_waddr = cnt_reg[V_W-1:0];
                    vi_wdata = 1'b0;
                    an_we    = 1'b1;
                    an_waddr = {LW'(0), cnt_reg[V_W-1:0]};
                    an_wdata = NONE;
                end
            end
            S_B_SEED:
            begin
                vi_we    = 1'b1;
                vi_waddr = u_reg;
                dp_we    = 1'b1;
                dp_waddr = u_reg;
                dp_wdata = '0;
                q_we     = 1'b1;
                q_waddr  = '0;
                q_wdata  = u_reg;
            end
            S_B_POPW:
            begin
                h_raddr  = q_rd;
                dp_raddr = q_rd;
            end
            S_B_VIS:
            begin
                if (nx_new)
                begin
                    vi_we = 1'b1;
                    dp_we = 1'b1;
                    an_we = 1'b1;
                    q_we  = qt_reg < VN_W'(MAX_VERTICES);
                end
            end
            S_L_RD:   an_raddr = {k_reg[LW-1:0], cnt_reg[V_W-1:0]};
            S_L_RDW:  an_raddr = {k_reg[LW-1:0], an_rd[V_W-1:0]};
            S_L_WR:
            begin
                an_we    = 1'b1;
                an_waddr = {kp1[LW-1:0], cnt_reg[V_W-1:0]};
                an_wdata = p_ok ? an_rd : NONE;
            end
            S_Q_VU:   vi_raddr = u_reg;
            S_Q_VV:   vi_raddr = v_reg;
            S_Q_VA:   vi_raddr = a_reg;
            S_S_LD:   dp_raddr = sel_x;
            S_S_DX:   dp_raddr = y_reg;
            S_S_DNA:  an_raddr = {k_reg[LW-1:0], y_reg};
            S_S_FIN:  an_raddr = {LW'(0), x_reg};
            S_S_DL:   dp_raddr = l_reg;
            default:  ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            built_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == S_RESP;
            unique case (state_reg)
                S_INIT:     cnt_reg <= cnt_reg + VN_W'(1);
                S_DISPATCH: cnt_reg <= '0;
                S_B_CLR:    if (!cnt_end) cnt_reg <= cnt_reg + VN_W'(1);
                S_B_POP:    if (!q_more) cnt_reg <= '0;
                S_L_RD:     if (!lift_done && cnt_end) cnt_reg <= '0;
                S_L_WR:     cnt_reg <= cnt_reg + VN_W'(1);
                S_A_WRV:    fill_reg <= fill_reg + EN_W'(2);
                default:    ;
            endcase
            if (cfg_we)
                built_reg <= 1'b0;
            else if (state_reg == S_L_RD && lift_done)
                built_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg  <= req.item.op;
                bad_reg <= req.item.bad;
                u_reg   <= V_W'(req.item.u);
                v_reg   <= V_W'(req.item.v);
                a_reg   <= V_W'(req.item.a);
            end
            S_DISPATCH:
            begin
                anc_reg   <= '0;
                dist0_reg <= '0;
                onp_reg   <= 1'b0;
                priority if (op_reg == CMD_QUERY && !built_reg)
                    status_reg <= STS_NOT_BUILT;
                else if (bad_reg)
                    status_reg <= STS_RANGE;
                else if (op_reg == CMD_ADD && fill_full)
                    status_reg <= STS_FULL;
                else
                    status_reg <= STS_OK;
            end
            S_B_SEED:
            begin
                qh_reg <= '0;
                qt_reg <= VN_W'(1);
            end
            S_B_POP:   k_reg <= '0;
            S_B_POPW:
            begin
                now_reg <= q_rd;
                qh_reg  <= qh_reg + VN_W'(1);
            end
            S_B_HEADW:
            begin
                e_reg  <= h_rd;
                cd_reg <= dp_rd;
            end
            S_B_TGTW:
            begin
                nx_reg <= tgt_rd;
                e_reg  <= link_rd;
            end
            S_B_VIS:
                if (nx_new && qt_reg < VN_W'(MAX_VERTICES))
                    qt_reg <= qt_reg + VN_W'(1);
            S_L_RD:    if (!lift_done && cnt_end) k_reg <= kp1;
            S_L_RDW:   p_reg <= an_rd;
            S_Q_VU:    ok_reg <= 1'b1;
            S_Q_VV:    ok_reg <= ok_reg & vi_rd;
            S_Q_VA:    ok_reg <= ok_reg & vi_rd;
            S_Q_VCHK:
            begin
                pair_reg <= 2'd0;
                if (!(ok_reg && vi_rd))
                    status_reg <= STS_UNREACHED;
            end
            S_S_LD:
            begin
                x_reg <= sel_x;
                y_reg <= sel_y;
            end
            S_S_DX:    dx_reg <= dp_rd;
            S_S_DY:    dy_reg <= dp_rd;
            S_S_SWAP:
            begin
                k_reg   <= '0;
                sum_reg <= {1'b0, dx_reg} + {1'b0, dy_reg};
                if (dx_reg < dy_reg)
                begin
                    x_reg    <= y_reg;
                    y_reg    <= x_reg;
                    diff_reg <= dy_reg - dx_reg;
                end
                else
                    diff_reg <= dx_reg - dy_reg;
            end
            S_S_UP:    if (k_reg != K_END && !dbit) k_reg <= kp1;
            S_S_UPW:
            begin
                if (rd_ok)
                    x_reg <= an_rd[V_W-1:0];
                k_reg <= kp1;
            end
            S_S_EQ:
            begin
                if (x_reg == y_reg)
                    l_reg <= x_reg;
                else
                    k_reg <= K_LAST;
            end
            S_S_DNA:   p_reg <= an_rd;
            S_S_DNB:
            begin
                if (p_reg != an_rd && p_ok && rd_ok)
                begin
                    x_reg <= p_reg[V_W-1:0];
                    y_reg <= an_rd[V_W-1:0];
                end
                if (k_reg != '0)
                    k_reg <= k_reg - KW'(1);
            end
            S_S_FINW:  l_reg <= rd_ok ? an_rd[V_W-1:0] : x_reg;
            S_S_DIST:
            begin
                pair_reg <= pair_reg + 2'd1;
                unique case (pair_reg)
                    2'd0:
                    begin
                        anc_reg   <= l_reg;
                        dist0_reg <= d_cur;
                    end
                    2'd1:    dist1_reg <= d_cur;
                    default: onp_reg <= (DP_W'(dist1_reg) + DP_W'(d_cur)) == DP_W'(dist0_reg);
                endcase
            end
            default: ;
        endcase
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign ancestor = NODE_W'(anc_reg);
    assign distance = dist0_reg;
    assign on_path  = onp_reg;

endmodule

/* rtl/tree_lca_binary_lifting_top.sv */
// Top level of the tree lowest-common-ancestor engine.
// Usage: pulse start with command/node_u/node_v/node_a while busy is low; the
// transaction is taken on that edge. Command 3 is not queued and gives no result.
// Each other command returns one transaction on status/ancestor/distance/
// on_path, marked by done for exactly one cycle; the receiver cannot stall.
// A two-entry command queue lets up to two commands wait while one runs;
// busy rises when the queue is full.
// A build clears the visited marks, walks the tree breadth-first from the root
// over the edge entries of each reached vertex, then fills the lifting table
// for levels 1 to LIFT_LEVELS-1. A query makes 3 passes, for (u,v), (u,a)
// and (a,v). An add edge writes both directed edge entries.
// vertex_count is written through cfg_we/cfg_wdata while idle; a write
// clears the built mark. After reset the adjacency heads of all MAX_VERTICES
// vertices are cleared, and busy stays high until that is done.
module tree_lca_binary_lifting_top import tlca_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int LIFT_LEVELS = DEF_LIFT_LEVELS,
    parameter int MAX_DIRECTED_EDGES = DEF_MAX_EDGES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [NODE_W-1:0] node_u,
    input  logic [NODE_W-1:0] node_v,
    input  logic [NODE_W-1:0] node_a,
    input  logic              cfg_we,
    input  logic [VC_W-1:0]   cfg_wdata,
    output logic              done,
    output logic [2:0]        status,
    output logic [NODE_W-1:0] ancestor,
    output logic [DIST_W-1:0] distance,
    output logic              on_path
);

    localparam int VN_W = $clog2(MAX_VERTICES) + 1;
    localparam int CW = (VN_W > VC_W) ? VN_W : VC_W;

    logic [CW-1:0] n_live;
    tlca_req_t     req;
    tlca_bk_t      bk;

    tlca_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .node_u    (node_u),
        .node_v    (node_v),
        .node_a    (node_a),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .n_live    (n_live),
        .req       (req),
        .bk        (bk)
    );

    tlca_back #(
        .MAX_VERTICES      (MAX_VERTICES),
        .LIFT_LEVELS       (LIFT_LEVELS),
        .MAX_DIRECTED_EDGES(MAX_DIRECTED_EDGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .bk       (bk),
        .cfg_we   (cfg_we),
        .n_live   (n_live),
        .done     (done),
        .status   (status),
        .ancestor (ancestor),
        .distance (distance),
        .on_path  (on_path)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STS_OK) |-> (ancestor == '0 && distance == '0 && !on_path))
        else $error("error result carries data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STS_OK || status == STS_NOT_BUILT || status == STS_RANGE ||
                  status == STS_FULL || status == STS_UNREACHED))
        else $error("undefined status code");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        bk.pop |-> (req.valid && bk.ready))
        else $error("queue popped while empty or initializing");

endmodule

/* sim/tree_lca_binary_lifting_top_tb.sv */
// Self-checking testbench for the tree LCA engine: directed table, then random tree phases.
module tree_lca_binary_lifting_top_tb;
    import tlca_pkg::*;

    localparam int NV = DEF_MAX_VERTICES;
    localparam int NL = DEF_LIFT_LEVELS;
    localparam int NE = DEF_MAX_EDGES;
    localparam int NO_VTX = NV;
    localparam int NO_EDGE = NE;
    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        status_t           st;
        logic [NODE_W-1:0] anc;
        logic [DIST_W-1:0] span;
        logic              onp;
    } answer_t;

    typedef struct {
        cmd_t              cmd;
        logic [NODE_W-1:0] u;
        logic [NODE_W-1:0] v;
        logic [NODE_W-1:0] a;
        bit                typed;
        answer_t           ans;
    } row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        command = CMD_ADD;
    logic [NODE_W-1:0] node_u = '0;
    logic [NODE_W-1:0] node_v = '0;
    logic [NODE_W-1:0] node_a = '0;
    logic              cfg_we = 1'b0;
    logic [VC_W-1:0]   cfg_wdata = '0;
    logic              done;
    logic [2:0]        status;
    logic [NODE_W-1:0] ancestor;
    logic [DIST_W-1:0] distance;
    logic              on_path;

    tree_lca_binary_lifting_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .node_u(node_u), .node_v(node_v), .node_a(node_a),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .done(done), .status(status), .ancestor(ancestor),
        .distance(distance), .on_path(on_path)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow state of the engine
    int unsigned vcount;
    int unsigned adj_head [NV];
    int unsigned edge_dst [NE];
    int unsigned edge_next [NE];
    int unsigned edges_used;
    bit          reached [NV];
    int unsigned depth [NV];
    int unsigned lift [NL][NV];
    int unsigned bfs_q [NV];
    bit          tables_built;

    answer_t pending_answers [$];
    int      errors = 0;
    int      n_items = 0, n_results = 0, n_builds = 0, n_queries = 0;
    longint  cycles = 0;
    int      burst_left = 0;
    int      labels [$];

    function automatic int unsigned live_n();
        if (vcount == 0) return 1;
        if (vcount > NV) return NV;
        return vcount;
    endfunction

    function automatic void shadow_build(int unsigned root, int unsigned n);
        int unsigned hd, tl, now, nx, e;
        hd = 0;
        tl = 0;
        for (int i = 0; i < NV; i++) reached[i] = 0;
        for (int i = 0; i < n; i++) lift[0][i] = NO_VTX;
        reached[root] = 1;
        depth[root] = 0;
        bfs_q[tl++] = root;
        while (hd < tl)
        begin
            now = bfs_q[hd++];
            e = adj_head[now];
            while (e < NO_EDGE)
            begin
                nx = edge_dst[e];
                if (nx < n && !reached[nx])
                begin
                    reached[nx] = 1;
                    depth[nx] = depth[now] + 1;
                    lift[0][nx] = now;
                    if (tl < NV) bfs_q[tl++] = nx;
                end
                e = edge_next[e];
            end
        end
        for (int k = 0; k + 1 < NL; k++)
            for (int i = 0; i < n; i++)
                lift[k+1][i] = (lift[k][i] < NO_VTX) ? lift[k][lift[k][i]] : NO_VTX;
        tables_built = 1;
    endfunction

    function automatic int unsigned meet_point(int unsigned x, int unsigned y);
        int unsigned t, diff, p, pa, pb;
        if (depth[x] < depth[y])
        begin
            t = x;
            x = y;
            y = t;
        end
        diff = depth[x] - depth[y];
        for (int k = 0; k < NL; k++)
            if ((diff >> k) & 1)
            begin
                p = lift[k][x];
                if (p < NO_VTX) x = p;
            end
        if (x == y) return x;
        for (int k = NL - 1; k >= 0; k--)
        begin
            pa = lift[k][x];
            pb = lift[k][y];
            if (pa != pb && pa < NO_VTX && pb < NO_VTX)
            begin
                x = pa;
                y = pb;
            end
        end
        p = lift[0][x];
        return (p < NO_VTX) ? p : x;
    endfunction

    function automatic int unsigned hops(int unsigned x, int unsigned y);
        int unsigned m;
        m = meet_point(x, y);
        return (depth[x] + depth[y] - 2 * depth[m]) & 11'h7FF;
    endfunction

    function automatic bit apply_command(cmd_t c, int unsigned u, int unsigned v,
                                         int unsigned a, output answer_t r);
        int unsigned n, d;
        n = live_n();
        r.st = STS_OK;
        r.anc = '0;
        r.span = '0;
        r.onp = 1'b0;
        if (c == CMD_NONE) return 0;
        if (c == CMD_ADD)
        begin
            if (u >= n || v >= n) r.st = STS_RANGE;
            else if (edges_used + 2 > NE) r.st = STS_FULL;
            else
            begin
                edge_dst[edges_used] = v;
                edge_next[edges_used] = adj_head[u];
                adj_head[u] = edges_used++;
                edge_dst[edges_used] = u;
                edge_next[edges_used] = adj_head[v];
                adj_head[v] = edges_used++;
            end
        end
        else if (c == CMD_BUILD)
        begin
            if (u >= n) r.st = STS_RANGE;
            else shadow_build(u, n);
        end
        else
        begin
            if (!tables_built) r.st = STS_NOT_BUILT;
            else if (u >= n || v >= n || a >= n) r.st = STS_RANGE;
            else if (!reached[u] || !reached[v] || !reached[a]) r.st = STS_UNREACHED;
            else
            begin
                r.anc = NODE_W'(meet_point(u, v));
                d = hops(u, v);
                r.span = DIST_W'(d);
                r.onp = (((hops(u, a) + hops(a, v)) & 12'hFFF) == d);
            end
        end
        return 1;
    endfunction

    task automatic issue(row_t row);
        answer_t pred;
        bit      has;
        start <= 1'b1;
        command <= row.cmd;
        node_u <= row.u;
        node_v <= row.v;
        node_a <= row.a;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        has = apply_command(row.cmd, row.u, row.v, row.a, pred);
        if (has) pending_answers = {pending_answers, (row.typed ? row.ans : pred)};
        n_items++;
        if (row.cmd == CMD_BUILD) n_builds++;
        if (row.cmd == CMD_QUERY) n_queries++;
        if (burst_left > 0) burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 15);
        end
    endtask

    task automatic send(cmd_t c, int unsigned u, int unsigned v, int unsigned a);
        row_t row;
        row.cmd = c;
        row.u = NODE_W'(u);
        row.v = NODE_W'(v);
        row.a = NODE_W'(a);
        row.typed = 0;
        row.ans = '{STS_OK, '0, '0, 1'b0};
        issue(row);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        @(negedge clk);
        while (busy) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_vertex_count(int unsigned val);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= VC_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        vcount = val & 11'h7FF;
        tables_built = 0;
    endtask

    task automatic noise();
        send(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
             $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    function automatic int pick();
        if (labels.size() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, live_n() - 1);
        return labels[$urandom_range(0, labels.size() - 1)];
    endfunction

    task automatic tree_phase(int unsigned val, bit full_chain);
        int unsigned n, m;
        int          lbl;
        set_vertex_count(val);
        n = live_n();
        labels.delete();
        send(CMD_QUERY, pick(), pick(), pick());
        m = full_chain ? n : $urandom_range(1, (n < 40) ? n : 40);
        for (int i = 0; i < m; i++)
        begin
            lbl = (n <= 64 || full_chain) ? i : $urandom_range(0, n - 1);
            labels = {labels, lbl};
            if (i > 0)
            begin
                if (full_chain || $urandom_range(0, 2) == 0)
                    send(CMD_ADD, labels[i-1], lbl, 0);
                else
                    send(CMD_ADD, lbl, labels[$urandom_range(0, i - 1)], $urandom_range(0, 1023));
            end
            if (!full_chain && $urandom_range(0, 9) == 0) noise();
        end
        send(CMD_BUILD, labels[$urandom_range(0, m - 1)], $urandom_range(0, 1023),
             $urandom_range(0, 1023));
        repeat ($urandom_range(20, 40))
        begin
            if ($urandom_range(0, 9) == 0) noise();
            else send(CMD_QUERY, pick(), pick(), pick());
        end
        send(CMD_ADD, pick(), pick(), 0);
        send(CMD_QUERY, pick(), pick(), pick());
        send(CMD_BUILD, pick(), 0, 0);
        repeat (10) send(CMD_QUERY, pick(), pick(), pick());
    endtask

    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d ancestor=%0d distance=%0d on_path=%0d",
                         $time, status, ancestor, distance, on_path);
                errors++;
            end
            else
            begin
                answer_t e;
                e = pending_answers.pop_front();
                n_results++;
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
                if (ancestor !== e.anc)
                begin
                    $display("%0t: ancestor expected %0d actual %0d", $time, e.anc, ancestor);
                    errors++;
                end
                if (distance !== e.span)
                begin
                    $display("%0t: distance expected %0d actual %0d", $time, e.span, distance);
                    errors++;
                end
                if (on_path !== e.onp)
                begin
                    $display("%0t: on_path expected %0d actual %0d", $time, e.onp, on_path);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL tree_lca_binary_lifting_top");
            $finish;
        end
    end

    row_t directed [] = '{
        '{CMD_QUERY, 3, 4, 5, 1, '{STS_NOT_BUILT, 0, 0, 0}},
        '{CMD_NONE, 1023, 1023, 1023, 1, '{STS_OK, 0, 0, 0}},
        '{CMD_ADD, 0, 1, 0, 1, '{STS_OK, 0, 0, 0}},
        '{CMD_ADD, 1, 1023, 0, 1, '{STS_OK, 0, 0, 0}},
        '{CMD_ADD, 1023, 512, 1023, 1, '{STS_OK, 0, 0, 0}},
        '{CMD_ADD, 1, 2, 0, 1, '{STS_OK, 0, 0, 0}},
        '{CMD_BUILD, 1023, 0, 0, 1, '{STS_OK, 0, 0, 0}},
        '{CMD_QUERY, 0, 2, 1, 0, '{STS_OK, 0, 0, 0}},
        '{CMD_QUERY, 512, 0, 1023, 0, '{STS_OK, 0, 0, 0}},
        '{CMD_QUERY, 1023, 1023, 1023, 0, '{STS_OK, 0, 0, 0}},
        '{CMD_QUERY, 0, 0, 0, 0, '{STS_OK, 0, 0, 0}},
        '{CMD_QUERY, 5, 0, 1, 1, '{STS_UNREACHED, 0, 0, 0}},
        '{CMD_ADD, 3, 4, 0, 1, '{STS_OK, 0, 0, 0}},
        '{CMD_QUERY, 3, 4, 0, 1, '{STS_UNREACHED, 0, 0, 0}},
        '{CMD_BUILD, 3, 0, 0, 1, '{STS_OK, 0, 0, 0}},
        '{CMD_QUERY, 3, 4, 4, 0, '{STS_OK, 0, 0, 0}},
        '{CMD_QUERY, 0, 1, 2, 1, '{STS_UNREACHED, 0, 0, 0}},
        '{CMD_BUILD, 0, 0, 0, 1, '{STS_OK, 0, 0, 0}},
        '{CMD_QUERY, 2, 512, 1, 0, '{STS_OK, 0, 0, 0}}
    };

    int unsigned phase_vals [] = '{0, 1, 2, 2047, 7, 33, 1024, 12, 64, 3, 20};

    initial
    begin
        vcount = VC_RESET;
        for (int i = 0; i < NV; i++)
        begin
            adj_head[i] = NO_EDGE;
            reached[i] = 0;
            depth[i] = 0;
        end
        edges_used = 0;
        tables_built = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) issue(directed[i]);
        foreach (phase_vals[i]) tree_phase(phase_vals[i], 0);
        tree_phase(100, 1);
        repeat (4) send(CMD_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d transactions (%0d builds, %0d queries), %0d results checked",
                 n_items, n_builds, n_queries, n_results);
        $display("edge store ended with %0d of %0d entries, %0d mismatches", edges_used, NE, errors);
        if (errors == 0)
            $display("PASS tree_lca_binary_lifting_top");
        else
            $display("FAIL tree_lca_binary_lifting_top");
        $finish;
    end

endmodule
